// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked assertion wrappers used by the checker file tc2d_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define TC2D_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// signal holds its value in the cycle after cond
`define TC2D_ASSERT_STABLE(name, clk, rstn, cond, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// File: rtl/core/tc2d_pkg.sv
// ----------------------------------------------------------------------------
// tc2d_pkg
// shared types and codes of the 2d template correlation block
// ----------------------------------------------------------------------------
package tc2d_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TMPL  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_TMPL_ROWS  = 2'd0,
    REG_TMPL_COLS  = 2'd1,
    REG_FRAME_ROWS = 2'd2,
    REG_FRAME_COLS = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  typedef struct packed {
    logic act;
    logic ok;
    logic last;
  } issue_t;

endpackage

// File: rtl/core/tc2d_ram.sv
// ----------------------------------------------------------------------------
// tc2d_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module tc2d_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/tc2d_ctrl.sv
// ----------------------------------------------------------------------------
// tc2d_ctrl
// size registers, item intake, store writes and the template window walk
// ----------------------------------------------------------------------------
module tc2d_ctrl import tc2d_pkg::*; #(
  parameter  int unsigned MAX_TEMPLATE_DIM = 8,
  parameter  int unsigned MAX_FRAME_DIM    = 32,
  localparam int unsigned RW  = (MAX_FRAME_DIM > 1) ? $clog2(MAX_FRAME_DIM) : 1,
  localparam int unsigned TDW = $clog2(MAX_TEMPLATE_DIM + 1),
  localparam int unsigned FDW = $clog2(MAX_FRAME_DIM + 1),
  localparam int unsigned CDW = (TDW > FDW) ? TDW : FDW,
  localparam int unsigned TIW = (MAX_TEMPLATE_DIM > 1) ? $clog2(MAX_TEMPLATE_DIM) : 1,
  localparam int unsigned TAW = (MAX_TEMPLATE_DIM > 1) ?
                                $clog2(MAX_TEMPLATE_DIM * MAX_TEMPLATE_DIM) : 1,
  localparam int unsigned FAW = $clog2(MAX_FRAME_DIM * MAX_FRAME_DIM)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     in_cmd_i,
  input  logic [RW-1:0]        in_row_i,
  input  logic [RW-1:0]        in_col_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [REG_IDX_W-1:0] cfg_index_i,
  input  logic [CDW-1:0]       cfg_data_i,
  input  logic                 mac_busy_i,
  output issue_t               issue_o,
  output logic                 tmpl_we_o,
  output logic [TAW-1:0]       tmpl_waddr_o,
  output logic [TAW-1:0]       tmpl_raddr_o,
  output logic                 frame_we_o,
  output logic [FAW-1:0]       frame_waddr_o,
  output logic [FAW-1:0]       frame_raddr_o
);

  localparam int unsigned M1 = (RW > FDW) ? RW : FDW;
  localparam int unsigned XW = ((M1 > TDW) ? M1 : TDW) + 1;
  localparam int unsigned PW = 2 * XW;

  state_e         state_q, state_d;
  cmd_e           cmd;
  logic [RW-1:0]  r_q, c_q;
  logic [TIW-1:0] wr_q, wr_d, wc_q, wc_d;
  logic [TDW-1:0] trows_q, tcols_q, t_clamp;
  logic [FDW-1:0] frows_q, fcols_q, f_clamp;
  logic [XW-1:0]  fr, fc;
  logic [PW-1:0]  t_waddr_full, f_waddr_full, t_raddr_full, f_raddr_full;
  logic           accept, in_tmpl, in_frame, wr_last, wc_last;

  assign cmd         = cmd_e'(in_cmd_i);
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // store writes
  assign in_tmpl  = (XW'(in_row_i) < XW'(trows_q)) && (XW'(in_col_i) < XW'(tcols_q));
  assign in_frame = (XW'(in_row_i) < XW'(frows_q)) && (XW'(in_col_i) < XW'(fcols_q));

  assign t_waddr_full = PW'(in_row_i) * PW'(MAX_TEMPLATE_DIM) + PW'(in_col_i);
  assign f_waddr_full = PW'(in_row_i) * PW'(MAX_FRAME_DIM) + PW'(in_col_i);

  assign tmpl_we_o     = accept && (cmd == CMD_TMPL) && in_tmpl;
  assign frame_we_o    = accept && (cmd == CMD_FRAME) && in_frame;
  assign tmpl_waddr_o  = t_waddr_full[TAW-1:0];
  assign frame_waddr_o = f_waddr_full[FAW-1:0];

  // window walk
  assign fr = XW'(r_q) + XW'(wr_q);
  assign fc = XW'(c_q) + XW'(wc_q);

  assign t_raddr_full = PW'(wr_q) * PW'(MAX_TEMPLATE_DIM) + PW'(wc_q);
  assign f_raddr_full = PW'(fr) * PW'(MAX_FRAME_DIM) + PW'(fc);

  assign tmpl_raddr_o  = t_raddr_full[TAW-1:0];
  assign frame_raddr_o = f_raddr_full[FAW-1:0];

  assign wr_last = (XW'(wr_q) == (XW'(trows_q) - XW'(1)));
  assign wc_last = (XW'(wc_q) == (XW'(tcols_q) - XW'(1)));

  assign issue_o.act  = (state_q == ST_WALK);
  assign issue_o.ok   = issue_o.act && (fr < XW'(frows_q)) && (fc < XW'(fcols_q));
  assign issue_o.last = issue_o.act && wr_last && wc_last;

  always_comb begin
    state_d = state_q;
    wr_d    = wr_q;
    wc_d    = wc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (cmd == CMD_QUERY)) begin
          state_d = ST_WALK;
          wr_d    = '0;
          wc_d    = '0;
        end
      end
      ST_WALK: begin
        if (wc_last) begin
          wc_d = '0;
          if (wr_last) begin
            state_d = ST_FLUSH;
          end else begin
            wr_d = wr_q + TIW'(1);
          end
        end else begin
          wc_d = wc_q + TIW'(1);
        end
      end
      ST_FLUSH: begin
        if (!mac_busy_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // size register clamping
  always_comb begin
    t_clamp = cfg_data_i[TDW-1:0];
    if (t_clamp == '0) begin
      t_clamp = TDW'(1);
    end else if (t_clamp > TDW'(MAX_TEMPLATE_DIM)) begin
      t_clamp = TDW'(MAX_TEMPLATE_DIM);
    end
    f_clamp = cfg_data_i[FDW-1:0];
    if (f_clamp == '0) begin
      f_clamp = FDW'(1);
    end else if (f_clamp > FDW'(MAX_FRAME_DIM)) begin
      f_clamp = FDW'(MAX_FRAME_DIM);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_q    <= '0;
      wc_q    <= '0;
      trows_q <= TDW'(MAX_TEMPLATE_DIM);
      tcols_q <= TDW'(MAX_TEMPLATE_DIM);
      frows_q <= FDW'(MAX_FRAME_DIM);
      fcols_q <= FDW'(MAX_FRAME_DIM);
    end else begin
      state_q <= state_d;
      wr_q    <= wr_d;
      wc_q    <= wc_d;
      if (cfg_valid_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_TMPL_ROWS:  trows_q <= t_clamp;
          REG_TMPL_COLS:  tcols_q <= t_clamp;
          REG_FRAME_ROWS: frows_q <= f_clamp;
          REG_FRAME_COLS: fcols_q <= f_clamp;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q <= in_row_i;
      c_q <= in_col_i;
    end
  end

endmodule

// File: rtl/core/tc2d_mac.sv
// ----------------------------------------------------------------------------
// tc2d_mac
// multiply-accumulate over the read stream and the result output register
// ----------------------------------------------------------------------------
module tc2d_mac import tc2d_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned OUT_W       = 38
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  issue_t                        issue_i,
  input  logic signed [SAMPLE_BITS-1:0] tmpl_data_i,
  input  logic signed [SAMPLE_BITS-1:0] frame_data_i,
  output logic                          busy_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OUT_W-1:0]       out_correlation_o
);

  localparam int unsigned PRW = 2 * SAMPLE_BITS;

  logic                    act1_q, ok1_q, last1_q, act2_q, last2_q;
  logic                    pending_q, pending_d, out_valid_q, out_valid_d;
  logic                    out_free, out_load;
  logic signed [PRW-1:0]   prod_d, prod_q;
  logic signed [OUT_W-1:0] acc_q, acc_d, sum, out_q, out_d;

  always_comb begin
    if (ok1_q) begin
      prod_d = tmpl_data_i * frame_data_i;
    end else begin
      prod_d = '0;
    end
  end

  assign sum      = acc_q + OUT_W'(prod_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    acc_d     = acc_q;
    pending_d = pending_q;
    out_load  = 1'b0;
    out_d     = sum;
    if (pending_q) begin
      if (out_free) begin
        out_load  = 1'b1;
        out_d     = acc_q;
        acc_d     = '0;
        pending_d = 1'b0;
      end
    end else if (act2_q) begin
      if (last2_q) begin
        if (out_free) begin
          out_load = 1'b1;
          acc_d    = '0;
        end else begin
          acc_d     = sum;
          pending_d = 1'b1;
        end
      end else begin
        acc_d = sum;
      end
    end
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act1_q      <= 1'b0;
      ok1_q       <= 1'b0;
      last1_q     <= 1'b0;
      act2_q      <= 1'b0;
      last2_q     <= 1'b0;
      pending_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      act1_q      <= issue_i.act;
      ok1_q       <= issue_i.ok;
      last1_q     <= issue_i.last;
      act2_q      <= act1_q;
      last2_q     <= last1_q;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign busy_o            = act1_q || act2_q || pending_q;
  assign out_valid_o       = out_valid_q;
  assign out_correlation_o = out_q;

endmodule

// File: rtl/core/template_correlation_2d.sv
// ----------------------------------------------------------------------------
// template_correlation_2d: query of N = template_rows * template_cols cells
// walks both stores cell by cell; items stall until the result is registered
// one multiply-accumulate per cell, one read port per store; writes do not stall
// reset restores full sizes; stores are not cleared
// ----------------------------------------------------------------------------
module template_correlation_2d import tc2d_pkg::*; #(
  parameter  int unsigned MAX_TEMPLATE_DIM = 8,
  parameter  int unsigned MAX_FRAME_DIM    = 32,
  parameter  int unsigned SAMPLE_BITS      = 16,
  localparam int unsigned RW    = (MAX_FRAME_DIM > 1) ? $clog2(MAX_FRAME_DIM) : 1,
  localparam int unsigned TDW   = $clog2(MAX_TEMPLATE_DIM + 1),
  localparam int unsigned FDW   = $clog2(MAX_FRAME_DIM + 1),
  localparam int unsigned CDW   = (TDW > FDW) ? TDW : FDW,
  localparam int unsigned TAW   = (MAX_TEMPLATE_DIM > 1) ?
                                  $clog2(MAX_TEMPLATE_DIM * MAX_TEMPLATE_DIM) : 1,
  localparam int unsigned FAW   = $clog2(MAX_FRAME_DIM * MAX_FRAME_DIM),
  localparam int unsigned OUT_W = 2 * SAMPLE_BITS +
                                  $clog2(MAX_TEMPLATE_DIM * MAX_TEMPLATE_DIM)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [CMD_W-1:0]              in_cmd_i,
  input  logic [RW-1:0]                 in_row_i,
  input  logic [RW-1:0]                 in_col_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OUT_W-1:0]       out_correlation_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [REG_IDX_W-1:0]          cfg_index_i,
  input  logic [CDW-1:0]                cfg_data_i
);

  issue_t                 issue;
  logic                   mac_busy;
  logic                   tmpl_we, frame_we;
  logic [TAW-1:0]         tmpl_waddr, tmpl_raddr;
  logic [FAW-1:0]         frame_waddr, frame_raddr;
  logic [SAMPLE_BITS-1:0] tmpl_rdata, frame_rdata;

  tc2d_ctrl #(
    .MAX_TEMPLATE_DIM (MAX_TEMPLATE_DIM),
    .MAX_FRAME_DIM    (MAX_FRAME_DIM)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_cmd_i      (in_cmd_i),
    .in_row_i      (in_row_i),
    .in_col_i      (in_col_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mac_busy_i    (mac_busy),
    .issue_o       (issue),
    .tmpl_we_o     (tmpl_we),
    .tmpl_waddr_o  (tmpl_waddr),
    .tmpl_raddr_o  (tmpl_raddr),
    .frame_we_o    (frame_we),
    .frame_waddr_o (frame_waddr),
    .frame_raddr_o (frame_raddr)
  );

  tc2d_ram #(
    .DEPTH (MAX_TEMPLATE_DIM * MAX_TEMPLATE_DIM),
    .WIDTH (SAMPLE_BITS),
    .AW    (TAW)
  ) u_tmpl_ram (
    .clk_i   (clk_i),
    .we_i    (tmpl_we),
    .waddr_i (tmpl_waddr),
    .wdata_i (in_sample_i),
    .raddr_i (tmpl_raddr),
    .rdata_o (tmpl_rdata)
  );

  tc2d_ram #(
    .DEPTH (MAX_FRAME_DIM * MAX_FRAME_DIM),
    .WIDTH (SAMPLE_BITS),
    .AW    (FAW)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (frame_we),
    .waddr_i (frame_waddr),
    .wdata_i (in_sample_i),
    .raddr_i (frame_raddr),
    .rdata_o (frame_rdata)
  );

  tc2d_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .OUT_W       (OUT_W)
  ) u_mac (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .issue_i           (issue),
    .tmpl_data_i       (tmpl_rdata),
    .frame_data_i      (frame_rdata),
    .busy_o            (mac_busy),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_correlation_o (out_correlation_o)
  );

endmodule

// File: rtl/core/tc2d_checker.sv
// ----------------------------------------------------------------------------
// tc2d_checker
// port-level checks of the 2d template correlation block, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tc2d_checker import tc2d_pkg::*; #(
  parameter int unsigned OUT_W = 38
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [CMD_W-1:0] in_cmd_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [OUT_W-1:0] out_correlation_o
);

  logic in_take, q_take, w_take, out_wait;

  assign in_take  = in_valid_i && !in_stall_o;
  assign q_take   = in_take && (in_cmd_i == CMD_QUERY);
  assign w_take   = in_take && (in_cmd_i != CMD_QUERY);
  assign out_wait = out_valid_o && out_stall_i;

  `TC2D_ASSERT(a_out_hold, clk_i, rst_ni, out_wait |=> out_valid_o, "result item dropped")
  `TC2D_ASSERT_STABLE(a_out_stable, clk_i, rst_ni, out_wait, out_correlation_o, "result changed")
  `TC2D_ASSERT(a_query_busy, clk_i, rst_ni, q_take |=> in_stall_o, "query item did not stall")
  `TC2D_ASSERT(a_write_free, clk_i, rst_ni, w_take |=> !in_stall_o, "write item stalled")
  `TC2D_ASSERT(a_result_busy, clk_i, rst_ni, $rose(out_valid_o) |-> in_stall_o, "stray result")

endmodule

bind template_correlation_2d tc2d_checker #(
  .OUT_W (OUT_W)
) u_tc2d_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .in_cmd_i          (in_cmd_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_correlation_o (out_correlation_o)
);

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of template_correlation_2d
// fills the template and the frame regions of the directed queries, then runs
// directed and random write and query items over several size settings with
// random idling on both channels; random queries read only written entries;
// a scoreboard predicts each correlation and checks results in order
// ----------------------------------------------------------------------------
module tb_top;
  import tc2d_pkg::*;

  localparam int unsigned TMPL_DIM  = 8;
  localparam int unsigned FRAME_DIM = 32;
  localparam int unsigned CORR_W    = 38;
  localparam int unsigned SETTLE    = 80;
  localparam int unsigned LIMIT     = 1000000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               in_cmd_i    = '0;
  logic [4:0]               in_row_i    = '0;
  logic [4:0]               in_col_i    = '0;
  logic signed [15:0]       in_sample_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [CORR_W-1:0] out_correlation_o;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [1:0]               cfg_index_i = '0;
  logic [5:0]               cfg_data_i  = '0;

  int send_idle_pct = 24;
  int recv_idle_pct = 64;
  int unsigned cycles = 0;

  class corr_board;
    int unsigned t_rows = TMPL_DIM;
    int unsigned t_cols = TMPL_DIM;
    int unsigned f_rows = FRAME_DIM;
    int unsigned f_cols = FRAME_DIM;
    logic signed [15:0] tmpl_mem [TMPL_DIM*TMPL_DIM];
    logic signed [15:0] frame_mem [FRAME_DIM*FRAME_DIM];
    bit frame_set [FRAME_DIM*FRAME_DIM];
    logic signed [CORR_W-1:0] corr_q [$];
    int errors = 0;

    function int unsigned clamp_dim(int unsigned v, int unsigned top);
      if (v < 1) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function void set_size(reg_e idx, logic [5:0] d);
      case (idx)
        REG_TMPL_ROWS:  t_rows = clamp_dim(int'(d[3:0]), TMPL_DIM);
        REG_TMPL_COLS:  t_cols = clamp_dim(int'(d[3:0]), TMPL_DIM);
        REG_FRAME_ROWS: f_rows = clamp_dim(int'(d), FRAME_DIM);
        REG_FRAME_COLS: f_cols = clamp_dim(int'(d), FRAME_DIM);
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return corr_q.size();
    endfunction

    // true when a query here reads only frame entries written so far
    function bit query_safe(logic [4:0] r, logic [4:0] cl);
      int unsigned ri;
      int unsigned ci;
      ri = int'(r);
      ci = int'(cl);
      for (int unsigned tr = 0; tr < t_rows; tr++) begin
        for (int unsigned tc = 0; tc < t_cols; tc++) begin
          if (ri + tr < f_rows && ci + tc < f_cols &&
              !frame_set[(ri + tr)*FRAME_DIM + ci + tc]) return 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_item(cmd_e c, logic [4:0] r, logic [4:0] cl, logic signed [15:0] s);
      longint acc;
      int unsigned ri;
      int unsigned ci;
      acc = 0;
      ri = int'(r);
      ci = int'(cl);
      case (c)
        CMD_TMPL: begin
          if (ri < t_rows && ci < t_cols) tmpl_mem[ri*TMPL_DIM + ci] = s;
        end
        CMD_FRAME: begin
          if (ri < f_rows && ci < f_cols) begin
            frame_mem[ri*FRAME_DIM + ci] = s;
            frame_set[ri*FRAME_DIM + ci] = 1'b1;
          end
        end
        CMD_QUERY: begin
          for (int unsigned tr = 0; tr < t_rows; tr++) begin
            for (int unsigned tc = 0; tc < t_cols; tc++) begin
              if (ri + tr < f_rows && ci + tc < f_cols) begin
                acc += longint'(tmpl_mem[tr*TMPL_DIM + tc]) *
                       longint'(frame_mem[(ri + tr)*FRAME_DIM + ci + tc]);
              end
            end
          end
          corr_q.push_back(acc[CORR_W-1:0]);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [CORR_W-1:0] got);
      logic signed [CORR_W-1:0] want;
      if (corr_q.size() == 0) begin
        $error("correlation: expected none, actual %0d", got);
        errors++;
      end else begin
        want = corr_q.pop_front();
        if (got !== want) begin
          $error("correlation: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  corr_board board = new();

  template_correlation_2d u_top (.*);

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_correlation_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("template_correlation_2d: mismatch");
      $finish;
    end
  end

  task automatic send_item(input cmd_e c, input logic [4:0] r, input logic [4:0] cl,
                           input logic signed [15:0] s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_cmd_i    <= c;
    in_row_i    <= r;
    in_col_i    <= cl;
    in_sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    board.note_item(c, r, cl, s);
  endtask

  // waits until the block is idle, then writes all four size registers
  task automatic set_sizes(input logic [5:0] t_r, input logic [5:0] t_c,
                           input logic [5:0] f_r, input logic [5:0] f_c);
    reg_e       order [4];
    logic [5:0] vals [4];
    order = '{REG_TMPL_ROWS, REG_TMPL_COLS, REG_FRAME_ROWS, REG_FRAME_COLS};
    vals  = '{t_r, t_c, f_r, f_c};
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      board.set_size(order[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_item();
    cmd_e               c;
    logic [4:0]         r;
    logic [4:0]         cl;
    logic signed [15:0] s;
    int                 w;
    int                 tries;
    w = $urandom_range(0, 99);
    if (w < 20) c = CMD_TMPL;
    else if (w < 60) c = CMD_FRAME;
    else if (w < 95) c = CMD_QUERY;
    else c = CMD_NOP;
    r  = 5'($urandom_range(0, 31));
    cl = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 3) != 0) begin
      // mostly in range of the store or frame in use
      if (c == CMD_TMPL) begin
        r  = 5'($urandom_range(0, board.t_rows - 1));
        cl = 5'($urandom_range(0, board.t_cols - 1));
      end else if (c == CMD_FRAME || c == CMD_QUERY) begin
        r  = 5'($urandom_range(0, board.f_rows - 1));
        cl = 5'($urandom_range(0, board.f_cols - 1));
      end
    end
    if (c == CMD_QUERY) begin
      tries = 0;
      while (!board.query_safe(r, cl) && tries < 16) begin
        r  = 5'($urandom_range(0, board.f_rows - 1));
        cl = 5'($urandom_range(0, board.f_cols - 1));
        tries++;
      end
      // the top left corner block is always written
      if (!board.query_safe(r, cl)) begin
        r  = '0;
        cl = '0;
      end
    end
    case ($urandom_range(0, 7))
      0:       s = 16'sh8000;
      1:       s = 16'sh7fff;
      default: s = 16'($urandom);
    endcase
    send_item(c, r, cl, s);
  endtask

  initial begin
    logic [4:0]         r;
    logic [4:0]         cl;
    logic signed [15:0] s;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_sizes(6'd8, 6'd8, 6'd32, 6'd32);

    // fill the template and the frame blocks that the directed queries read
    for (int i = 0; i < 64; i++) begin
      send_item(CMD_TMPL, 5'(i / 8), 5'(i % 8), 16'sh8000);
    end
    for (int i = 0; i < 128; i++) begin
      r  = 5'(i / 8);
      cl = 5'(i % 8);
      if (r < 8) s = 16'sh8000;
      else s = 16'sh7fff;
      send_item(CMD_FRAME, r, cl, s);
    end
    for (int i = 0; i < 64; i++) begin
      send_item(CMD_FRAME, 5'(24 + i / 8), 5'(24 + i % 8), 16'($urandom));
    end
    for (int i = 0; i < 8; i++) begin
      send_item(CMD_FRAME, 5'd31, 5'(i), 16'($urandom));
      send_item(CMD_FRAME, 5'(i), 5'd31, 16'($urandom));
    end

    send_item(CMD_QUERY, 5'd0, 5'd0, 16'sh0000);
    send_item(CMD_QUERY, 5'd8, 5'd0, 16'shffff);
    send_item(CMD_QUERY, 5'd31, 5'd31, 16'sh0000);
    send_item(CMD_QUERY, 5'd25, 5'd25, 16'sh0000);
    send_item(CMD_QUERY, 5'd31, 5'd0, 16'sh0000);
    send_item(CMD_QUERY, 5'd0, 5'd31, 16'sh0000);
    send_item(CMD_TMPL, 5'd7, 5'd7, 16'sh7fff);
    send_item(CMD_FRAME, 5'd31, 5'd31, 16'sh8000);
    send_item(CMD_QUERY, 5'd24, 5'd24, 16'sh0000);
    send_item(CMD_TMPL, 5'd8, 5'd0, 16'sh1234);
    send_item(CMD_TMPL, 5'd0, 5'd31, 16'sh7fff);
    send_item(CMD_TMPL, 5'd31, 5'd31, 16'sh0001);
    send_item(CMD_NOP, 5'd31, 5'd31, 16'shffff);
    send_item(CMD_QUERY, 5'd0, 5'd0, 16'sh0000);
    send_item(CMD_TMPL, 5'd0, 5'd0, 16'sh0000);
    send_item(CMD_QUERY, 5'd0, 5'd0, 16'sh0000);
    send_item(CMD_FRAME, 5'd0, 5'd0, 16'sh7fff);
    send_item(CMD_QUERY, 5'd0, 5'd0, 16'sh0000);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_idle_pct = 64;
        recv_idle_pct = 24;
      end
      if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0:       ;
        1:       set_sizes(6'd1, 6'd1, 6'd1, 6'd1);
        2:       set_sizes(6'd0, 6'd15, 6'd63, 6'd0);
        3:       set_sizes(6'd3, 6'd5, 6'd9, 6'd20);
        default: set_sizes(6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom));
      endcase
      repeat (50) random_item();
    end

    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("template_correlation_2d: match");
    end else begin
      $display("template_correlation_2d: mismatch");
    end
    $finish;
  end

endmodule
